FILE: design/esd_pkg.sv
// Shared types, character codes and helper functions of the escape sequence decoder.
package esd_pkg;

    typedef struct packed {
        logic [7:0] char_val;
        logic       last;
    } word_t;

    typedef struct packed {
        logic [1:0] count;
        word_t      w0;
        word_t      w1;
    } push_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_LOW_M     = 8'h6D;
    localparam logic [7:0] CH_UP_M      = 8'h4D;
    localparam logic [7:0] CH_LOW_X     = 8'h78;
    localparam logic [7:0] CH_UP_X      = 8'h58;
    localparam logic [7:0] CH_LOW_O     = 8'h6F;
    localparam logic [7:0] CH_UP_O      = 8'h4F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOW_A     = 8'h61;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_LOW_N     = 8'h6E;
    localparam logic [7:0] CH_LOW_T     = 8'h74;
    localparam logic [7:0] CH_LOW_B     = 8'h62;
    localparam logic [7:0] CH_LOW_R     = 8'h72;
    localparam logic [7:0] CTRL_MASK    = 8'h1F;
    localparam logic [7:0] META_BIT     = 8'h80;

    function automatic logic [7:0] c_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            CH_LOW_N: r = 8'h0A;
            CH_LOW_T: r = 8'h09;
            CH_LOW_B: r = 8'h08;
            CH_LOW_R: r = 8'h0D;
            default:  r = c;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] with_meta(input logic [7:0] v, input logic meta);
        return meta ? (v | META_BIT) : v;
    endfunction

endpackage

FILE: design/esd_decode.sv
// Parse state registers and combinational decode of one input word into up to two result words.
module esd_decode (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_accept,
    input  logic [7:0]    in_char,
    input  logic          in_last,
    output esd_pkg::push_t push
);
    import esd_pkg::*;

    typedef enum logic [2:0] {PH_IDLE, PH_BS, PH_BSM, PH_BSN, PH_NUM, PH_CARET} phase_t;
    typedef enum logic [1:0] {RADIX_DEC, RADIX_HEX, RADIX_OCT} radix_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    typedef struct packed {
        logic   emit;
        phase_t phase;
        word_t  w;
    } lead_t;

    phase_t     phase_reg, phase_next;
    logic       meta_reg, meta_next;
    logic [9:0] accum_reg, accum_next;
    logic [1:0] count_reg, count_next;
    radix_t     radix_reg, radix_next;
    logic [7:0] held_reg, held_next;
    push_t      res;

    function automatic digit_t digit_of(input logic [7:0] c, input radix_t rad);
        digit_t d;
        d = '0;
        unique case (rad)
            RADIX_HEX: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    d = '{1'b1, 4'(c - CH_ZERO)};
                end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
                    d = '{1'b1, 4'(c - CH_LOW_A + 8'd10)};
                end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                    d = '{1'b1, 4'(c - CH_UP_A + 8'd10)};
                end
            end
            RADIX_OCT: begin
                if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    d = '{1'b1, 4'(c - CH_ZERO)};
                end
            end
            default: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    d = '{1'b1, 4'(c - CH_ZERO)};
                end
            end
        endcase
        return d;
    endfunction

    // A byte that opens a decoded item: a backslash or caret leads a sequence unless it ends
    // the string, anything else is emitted as it stands, with bit 7 set under a meta prefix.
    function automatic lead_t lead_char(input logic [7:0] c, input logic last, input logic meta);
        lead_t r;
        r.emit  = 1'b0;
        r.phase = PH_IDLE;
        r.w     = '{with_meta(c, meta), last};
        if (!last && c == CH_BACKSLASH) begin
            r.phase = PH_BS;
        end else if (!last && c == CH_CARET) begin
            r.phase = PH_CARET;
        end else begin
            r.emit = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [9:0] scale(input logic [9:0] a, input radix_t rad);
        logic [9:0] r;
        unique case (rad)
            RADIX_HEX: r = {a[5:0], 4'b0};
            RADIX_OCT: r = {a[6:0], 3'b0};
            default:   r = {a[6:0], 3'b0} + {a[8:0], 1'b0};
        endcase
        return r;
    endfunction

    always_comb begin
        lead_t      lr;
        digit_t     dg;
        logic [9:0] src_acc;
        logic [1:0] src_cnt;
        radix_t     src_rad;
        logic [1:0] maxd;
        logic [9:0] acc2;
        logic [1:0] cnt2;

        phase_next = phase_reg;
        meta_next  = meta_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        radix_next = radix_reg;
        held_next  = held_reg;
        res        = '0;
        lr         = '0;
        dg         = '0;
        src_acc    = accum_reg;
        src_cnt    = count_reg;
        src_rad    = radix_reg;
        maxd       = 2'd3;
        acc2       = '0;
        cnt2       = '0;

        unique case (phase_reg)
            PH_BS: begin
                if (!meta_reg && (in_char == CH_LOW_M || in_char == CH_UP_M) && !in_last) begin
                    phase_next = PH_BSM;
                end else if (!in_last && ((in_char >= CH_ZERO && in_char <= CH_NINE)
                        || in_char == CH_LOW_X || in_char == CH_UP_X
                        || in_char == CH_LOW_O || in_char == CH_UP_O)) begin
                    held_next  = in_char;
                    phase_next = PH_BSN;
                end else begin
                    res.count  = 2'd1;
                    res.w0     = '{with_meta(c_escape(in_char), meta_reg), in_last};
                    phase_next = PH_IDLE;
                    meta_next  = 1'b0;
                    accum_next = '0;
                    count_next = '0;
                    radix_next = RADIX_DEC;
                    held_next  = '0;
                end
            end
            PH_BSN, PH_NUM: begin
                if (phase_reg == PH_BSN) begin
                    if (held_reg == CH_LOW_X || held_reg == CH_UP_X) begin
                        src_rad = RADIX_HEX;
                        src_acc = '0;
                        src_cnt = '0;
                    end else if (held_reg == CH_LOW_O || held_reg == CH_UP_O) begin
                        src_rad = RADIX_OCT;
                        src_acc = '0;
                        src_cnt = '0;
                    end else begin
                        src_rad = RADIX_DEC;
                        src_acc = {6'b0, 4'(held_reg - CH_ZERO)};
                        src_cnt = 2'd1;
                    end
                end
                maxd = (src_rad == RADIX_HEX) ? 2'd2 : 2'd3;
                dg   = digit_of(in_char, src_rad);
                if (dg.ok && src_cnt < maxd) begin
                    acc2 = scale(src_acc, src_rad) + {6'b0, dg.val};
                    cnt2 = src_cnt + 2'd1;
                    if (cnt2 >= maxd || in_last) begin
                        res.count  = 2'd1;
                        res.w0     = '{with_meta(acc2[7:0], meta_reg), in_last};
                        phase_next = PH_IDLE;
                        meta_next  = 1'b0;
                        accum_next = '0;
                        count_next = '0;
                        radix_next = RADIX_DEC;
                        held_next  = '0;
                    end else begin
                        phase_next = PH_NUM;
                        accum_next = acc2;
                        count_next = cnt2;
                        radix_next = src_rad;
                    end
                end else begin
                    res.w0     = '{with_meta(src_acc[7:0], meta_reg), 1'b0};
                    lr         = lead_char(in_char, in_last, 1'b0);
                    res.count  = lr.emit ? 2'd2 : 2'd1;
                    res.w1     = lr.w;
                    phase_next = lr.phase;
                    meta_next  = 1'b0;
                    accum_next = '0;
                    count_next = '0;
                    radix_next = RADIX_DEC;
                    held_next  = '0;
                end
            end
            PH_CARET: begin
                res.count  = 2'd1;
                res.w0     = '{with_meta(in_char & CTRL_MASK, meta_reg), in_last};
                phase_next = PH_IDLE;
                meta_next  = 1'b0;
                accum_next = '0;
                count_next = '0;
                radix_next = RADIX_DEC;
                held_next  = '0;
            end
            default: begin
                // Idle and the state after a meta prefix take an opening byte; under a meta prefix bit 7 is forced on.
                lr         = lead_char(in_char, in_last, (phase_reg == PH_BSM) | meta_reg);
                res.count  = lr.emit ? 2'd1 : 2'd0;
                res.w0     = lr.w;
                phase_next = lr.phase;
                meta_next  = lr.emit ? 1'b0 : ((phase_reg == PH_BSM) | meta_reg);
                accum_next = '0;
                count_next = '0;
                radix_next = RADIX_DEC;
                held_next  = '0;
            end
        endcase
    end

    assign push = in_accept ? res : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            meta_reg  <= 1'b0;
            accum_reg <= '0;
            count_reg <= '0;
            radix_reg <= RADIX_DEC;
            held_reg  <= '0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            meta_reg  <= meta_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
            radix_reg <= radix_next;
            held_reg  <= held_next;
        end
    end

endmodule

FILE: design/esd_out_fifo.sv
// Result queue that takes up to two words per cycle and hands out one word per cycle on pop.
module esd_out_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  esd_pkg::push_t push,
    input  logic           pop,
    output esd_pkg::word_t head,
    output logic           not_empty,
    output logic           room
);
    import esd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    word_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign head      = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.w0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push.w1;
        end
    end

endmodule

FILE: design/escape_sequence_decoder_core.sv
// Top level of the escape sequence decoder: parse logic feeding a small result queue.
//
// The s_ channel carries the escaped text, one nonzero byte per word, with s_last on the
// final byte of a string. The m_ channel carries the decoded bytes, one per word, with
// m_last on the final decoded byte of the string.
// Each accepted input word is decoded in the cycle it is taken and produces zero, one or
// two result words, written into the result queue at the same clock edge. A result
// appears on the m_ channel from the queue's storage, behind any words already queued.
// Input words are taken in every cycle while the queue has room for two more words, so
// one byte per cycle is sustained whenever the receiver drains one word per cycle; a
// word that yields two results puts two words into the queue for the output.
// When the receiver stalls, the queue of DEPTH words fills and s_ready drops once fewer
// than two places are free; nothing is lost or repeated.
// Reset empties the queue and returns the parser to idle with no pending sequence;
// s_ready is high right after reset.
module escape_sequence_decoder_core #(
    parameter int DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char,
    input  logic       s_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char,
    output logic       m_last
);
    import esd_pkg::*;

    push_t push;
    word_t head;
    logic  accept;

    assign accept = s_valid && s_ready;

    esd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_char   (s_char),
        .in_last   (s_last),
        .push      (push)
    );

    esd_out_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .pop       (m_ready),
        .head      (head),
        .not_empty (m_valid),
        .room      (s_ready)
    );

    assign m_char = head.char_val;
    assign m_last = head.last;

endmodule

FILE: design/esd_checker.sv
// Port-level checks of the escape sequence decoder and their binding to the top level.
module esd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_char,
    input logic       m_last
);

    // The queue is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result queue not empty after reset");

    // A result word never appears without an input word having been taken.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !(s_valid && s_ready)) |=> !m_valid)
        else $error("result word appeared without input");

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_char) && $stable(m_last))
        else $error("stalled result word changed");

    // An empty queue always has room for another input word.
    a_room_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while result queue empty");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (.*);
